@@ design/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg: shared types of the sparse extent map
// cell command codes, the command bundle and the per-cell status flags
// ----------------------------------------------------------------------------
package sem_pkg;

  // cell operations, issued to every cell of the chain at once
  typedef enum logic [2:0] {
    OP_IDLE = 3'd0,
    OP_PRE  = 3'd1,
    OP_CLS  = 3'd2,
    OP_EVL  = 3'd3,
    OP_APL  = 3'd4,
    OP_INS  = 3'd5,
    OP_SHL  = 3'd6
  } sem_op_e;

  typedef struct packed {
    sem_op_e op;
    logic    wr;
    logic    commit;
    logic    any_hole;
  } sem_cmd_t;

  typedef struct packed {
    logic vld;
    logic tail;
    logic hole;
    logic cov;
    logic cov2;
    logic sp;
    logic mg;
    logic rdv;
    logic nx;
  } sem_flg_t;

endpackage

@@ design/sparse_extent_map_core.sv @@
// ----------------------------------------------------------------------------
// sparse_extent_map_core: sorted extent table with range overwrite and lookup
// a chain of extent slots kept sorted and packed from slot 0; writes trim,
// split, remove and insert extents, reads translate one logical offset
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o| action, logical_start, disk_offset, length
//  out     | out_valid_o/out_stall_i| mapped offset, length, gap, next, full
//
// a read runs from accept through end compute, classify, evaluate, collect,
// gap subtract and result load; a write runs end compute, classify, evaluate
// and apply, then one insert per piece (new extent, split tail) and one shift
// per removed extent that the new extent does not take over, as the chain
// tail moves one slot a cycle, then result load; a write dropped on a full
// table skips insert and shift, and a zero-length write goes straight to
// result load; one word is in flight at a time; a new word is taken once the
// result is loaded into the output register, which holds under out_stall_i
// reset empties the table at once (slot valid bits), no clearing pass
//
module sparse_extent_map_core #(
  parameter int TABLE_ENTRIES = 64,
  parameter int OFFSET_BITS   = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   action_i,
  input  logic [OFFSET_BITS-1:0] logical_start_i,
  input  logic [OFFSET_BITS-1:0] disk_offset_i,
  input  logic [OFFSET_BITS-1:0] range_length_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OFFSET_BITS-1:0] mapped_disk_offset_o,
  output logic [OFFSET_BITS-1:0] mapped_length_o,
  output logic [OFFSET_BITS-1:0] gap_to_next_o,
  output logic                   has_next_o,
  output logic                   table_full_o
);
  import sem_pkg::*;

  localparam int N = TABLE_ENTRIES;
  localparam int W = OFFSET_BITS;
  localparam logic [W:0] LIM = {1'b1, {W{1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PRE  = 9'b000000010,
    ST_CLS  = 9'b000000100,
    ST_EVL  = 9'b000001000,
    ST_APL  = 9'b000010000,
    ST_INS  = 9'b000100000,
    ST_SHL  = 9'b001000000,
    ST_GAP  = 9'b010000000,
    ST_DONE = 9'b100000000
  } sem_state_e;

  sem_state_e state_q, state_d;

  // request registers: write range is clipped at the top of the address space
  logic         act_q, act_d;
  logic [W-1:0] key_q, key_d, dsk_q, dsk_d, len_q, len_d;
  logic [W:0]   end_q, end_d;

  // pending pieces to insert: new extent, then the split tail
  logic         i0_q, i0_d, i1_q, i1_d;
  logic [W-1:0] i1dk_q, i1dk_d, i1ln_q, i1ln_d;

  // collected result
  logic         rhit_q, rhit_d, rhn_q, rhn_d, rfull_q, rfull_d;
  logic [W-1:0] rdk_q, rdk_d, rln_q, rln_d, rnx_q, rnx_d, gap_q, gap_d;
  logic [W:0]   rend_q, rend_d;

  // output register
  logic         ovld_q, ovld_d, ohn_q, ohn_d, ofull_q, ofull_d;
  logic [W-1:0] odk_q, odk_d, oln_q, oln_d, ogap_q, ogap_d;

  sem_cmd_t     cmd;
  logic [W-1:0] ins_st, ins_dk, ins_ln;

  // chain wiring
  sem_flg_t     flg   [N];
  logic [W-1:0] st_a  [N];
  logic [W-1:0] dk_a  [N];
  logic [W-1:0] ln_a  [N];
  logic [W-1:0] cdk_a [N];
  logic [W-1:0] cln_a [N];
  logic [W-1:0] cst_a [N];
  logic [W:0]   cend_a[N];
  logic [N-1:0] vld_vec;

  // reductions over the chain
  logic         any_mg, any_sp, any_cov, any_cov2, any_rdv, any_nx, any_hole;
  logic [W-1:0] red_dk, red_ln, red_st;
  logic [W:0]   red_end;

  logic         accept, ovf, ins1, ins2;
  logic [W:0]   sum_x, lms_x, run_end, diff_x;

  assign accept     = in_valid_i & !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic         l_vld, l_tail, r_vld, r_tail, r_hole, r_cov;
    logic [W-1:0] l_st, l_dk, l_ln, r_st, r_dk, r_ln;

    if (k == 0) begin : g_lo
      assign l_vld  = 1'b0;
      assign l_tail = 1'b0;
      assign l_st   = '0;
      assign l_dk   = '0;
      assign l_ln   = '0;
    end else begin : g_lm
      assign l_vld  = flg[k-1].vld;
      assign l_tail = flg[k-1].tail;
      assign l_st   = st_a[k-1];
      assign l_dk   = dk_a[k-1];
      assign l_ln   = ln_a[k-1];
    end

    if (k == N-1) begin : g_hi
      // past the last slot the table reads as empty
      assign r_vld  = 1'b0;
      assign r_tail = 1'b1;
      assign r_hole = 1'b0;
      assign r_cov  = 1'b0;
      assign r_st   = '0;
      assign r_dk   = '0;
      assign r_ln   = '0;
    end else begin : g_hm
      assign r_vld  = flg[k+1].vld;
      assign r_tail = flg[k+1].tail;
      assign r_hole = flg[k+1].hole;
      assign r_cov  = flg[k+1].cov;
      assign r_st   = st_a[k+1];
      assign r_dk   = dk_a[k+1];
      assign r_ln   = ln_a[k+1];
    end

    sem_cell #(
      .OFFSET_BITS(W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .key_i   (key_q),
      .end_i   (end_q),
      .dsk_i   (dsk_q),
      .len_i   (len_q),
      .ins_st_i(ins_st),
      .ins_dk_i(ins_dk),
      .ins_ln_i(ins_ln),
      .l_vld_i (l_vld),
      .l_st_i  (l_st),
      .l_dk_i  (l_dk),
      .l_ln_i  (l_ln),
      .l_tail_i(l_tail),
      .r_vld_i (r_vld),
      .r_st_i  (r_st),
      .r_dk_i  (r_dk),
      .r_ln_i  (r_ln),
      .r_tail_i(r_tail),
      .r_hole_i(r_hole),
      .r_cov_i (r_cov),
      .flg_o   (flg[k]),
      .st_o    (st_a[k]),
      .dk_o    (dk_a[k]),
      .ln_o    (ln_a[k]),
      .c_dk_o  (cdk_a[k]),
      .c_ln_o  (cln_a[k]),
      .c_st_o  (cst_a[k]),
      .c_end_o (cend_a[k])
    );

    assign vld_vec[k] = flg[k].vld;
  end

  // at most one slot contributes to each bus, so an or-tree selects it
  always_comb begin
    any_mg   = 1'b0;
    any_sp   = 1'b0;
    any_cov  = 1'b0;
    any_cov2 = 1'b0;
    any_rdv  = 1'b0;
    any_nx   = 1'b0;
    any_hole = 1'b0;
    red_dk   = '0;
    red_ln   = '0;
    red_st   = '0;
    red_end  = '0;
    for (int k = 0; k < N; k++) begin
      any_mg   = any_mg   | flg[k].mg;
      any_sp   = any_sp   | flg[k].sp;
      any_cov  = any_cov  | flg[k].cov;
      any_cov2 = any_cov2 | flg[k].cov2;
      any_rdv  = any_rdv  | flg[k].rdv;
      any_nx   = any_nx   | flg[k].nx;
      any_hole = any_hole | flg[k].hole;
      red_dk   = red_dk   | cdk_a[k];
      red_ln   = red_ln   | cln_a[k];
      red_st   = red_st   | cst_a[k];
      red_end  = red_end  | cend_a[k];
    end
  end

  // table growth: one for the new extent unless it merges, one for a split;
  // removed entries free slots; count is known from the last two valid bits
  assign ins2 = any_sp & !any_mg;
  assign ins1 = any_sp ^ !any_mg;
  always_comb begin
    ovf = 1'b0;
    if (ins2) begin
      ovf = (!any_cov & vld_vec[N-2]) | (any_cov & !any_cov2 & vld_vec[N-1]);
    end else if (ins1) begin
      ovf = !any_cov & vld_vec[N-1];
    end
  end

  // clip the written range so that it ends no higher than the top of the address space
  assign sum_x = {1'b0, logical_start_i} + {1'b0, range_length_i};
  assign lms_x = LIM - {1'b0, logical_start_i};

  // read: the run ends where the mapped extent ends, or at the query in a gap
  assign run_end = rhit_q ? rend_q : {1'b0, key_q};
  assign diff_x  = {1'b0, rnx_q} - run_end;

  // piece to insert this cycle
  assign ins_st = i0_q ? key_q : end_q[W-1:0];
  assign ins_dk = i0_q ? dsk_q : i1dk_q;
  assign ins_ln = i0_q ? len_q : i1ln_q;

  always_comb begin
    cmd.op       = OP_IDLE;
    cmd.wr       = act_q;
    cmd.commit   = act_q & !ovf;
    cmd.any_hole = any_hole;
    unique case (state_q)
      ST_PRE:  cmd.op = OP_PRE;
      ST_CLS:  cmd.op = OP_CLS;
      ST_EVL:  cmd.op = OP_EVL;
      ST_APL:  cmd.op = OP_APL;
      ST_INS:  cmd.op = (i0_q | i1_q) ? OP_INS : OP_IDLE;
      ST_SHL:  cmd.op = any_hole ? OP_SHL : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    key_d   = key_q;
    dsk_d   = dsk_q;
    len_d   = len_q;
    end_d   = end_q;
    i0_d    = i0_q;
    i1_d    = i1_q;
    i1dk_d  = i1dk_q;
    i1ln_d  = i1ln_q;
    rhit_d  = rhit_q;
    rhn_d   = rhn_q;
    rfull_d = rfull_q;
    rdk_d   = rdk_q;
    rln_d   = rln_q;
    rnx_d   = rnx_q;
    rend_d  = rend_q;
    gap_d   = gap_q;
    ovld_d  = ovld_q & out_stall_i;
    ohn_d   = ohn_q;
    ofull_d = ofull_q;
    odk_d   = odk_q;
    oln_d   = oln_q;
    ogap_d  = ogap_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          act_d   = action_i;
          key_d   = logical_start_i;
          dsk_d   = disk_offset_i;
          rfull_d = 1'b0;
          if (sum_x > LIM) begin
            end_d = LIM;
            len_d = lms_x[W-1:0];
          end else begin
            end_d = sum_x;
            len_d = range_length_i;
          end
          // a zero-length write leaves the table alone
          state_d = (action_i && (range_length_i == '0)) ? ST_DONE : ST_PRE;
        end
      end
      ST_PRE:  state_d = ST_CLS;
      ST_CLS:  state_d = ST_EVL;
      ST_EVL:  state_d = ST_APL;
      ST_APL: begin
        if (act_q) begin
          rfull_d = ovf;
          i0_d    = !ovf & !any_mg;
          i1_d    = !ovf & any_sp;
          i1dk_d  = red_dk;
          i1ln_d  = red_ln;
          state_d = ovf ? ST_DONE : ST_INS;
        end else begin
          rhit_d  = any_rdv;
          rhn_d   = any_nx;
          rdk_d   = red_dk;
          rln_d   = red_ln;
          rnx_d   = red_st;
          rend_d  = red_end;
          state_d = ST_GAP;
        end
      end
      ST_INS: begin
        priority if (i0_q) begin
          i0_d = 1'b0;
        end else if (i1_q) begin
          i1_d = 1'b0;
        end else begin
          state_d = ST_SHL;
        end
      end
      ST_SHL: begin
        if (!any_hole) begin
          state_d = ST_DONE;
        end
      end
      ST_GAP: begin
        gap_d   = (rhn_q && ({1'b0, rnx_q} >= run_end)) ? diff_x[W-1:0] : '0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovld_q || !out_stall_i) begin
          ovld_d  = 1'b1;
          ofull_d = act_q & rfull_q;
          ohn_d   = !act_q & rhn_q;
          odk_d   = act_q ? '0 : rdk_q;
          oln_d   = act_q ? '0 : rln_q;
          ogap_d  = act_q ? '0 : gap_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i0_q    <= 1'b0;
      i1_q    <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i0_q    <= i0_d;
      i1_q    <= i1_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    key_q   <= key_d;
    dsk_q   <= dsk_d;
    len_q   <= len_d;
    end_q   <= end_d;
    i1dk_q  <= i1dk_d;
    i1ln_q  <= i1ln_d;
    rhit_q  <= rhit_d;
    rhn_q   <= rhn_d;
    rfull_q <= rfull_d;
    rdk_q   <= rdk_d;
    rln_q   <= rln_d;
    rnx_q   <= rnx_d;
    rend_q  <= rend_d;
    gap_q   <= gap_d;
    ohn_q   <= ohn_d;
    ofull_q <= ofull_d;
    odk_q   <= odk_d;
    oln_q   <= oln_d;
    ogap_q  <= ogap_d;
  end

  assign out_valid_o          = ovld_q;
  assign mapped_disk_offset_o = odk_q;
  assign mapped_length_o      = oln_q;
  assign gap_to_next_o        = ogap_q;
  assign has_next_o           = ohn_q;
  assign table_full_o         = ofull_q;

`ifndef SYNTHESIS
  // an accepted word always starts work
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted word did not leave idle");

  // between words the table is packed from slot 0 without gaps
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("extent table not packed");

  // all removed slots are squeezed out before the result is given
  a_nohole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> !any_hole)
    else $error("hole left in extent table");
`endif

endmodule

@@ design/sem_cell.sv @@
// ----------------------------------------------------------------------------
// sem_cell: one extent slot of the chain
// classifies its extent against the request, trims or merges it in place and
// moves it to a neighbor slot when entries are inserted or removed
// ----------------------------------------------------------------------------
module sem_cell #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sem_pkg::sem_cmd_t        cmd_i,
  input  logic [OFFSET_BITS-1:0]   key_i,
  input  logic [OFFSET_BITS:0]     end_i,
  input  logic [OFFSET_BITS-1:0]   dsk_i,
  input  logic [OFFSET_BITS-1:0]   len_i,
  input  logic [OFFSET_BITS-1:0]   ins_st_i,
  input  logic [OFFSET_BITS-1:0]   ins_dk_i,
  input  logic [OFFSET_BITS-1:0]   ins_ln_i,
  input  logic                     l_vld_i,
  input  logic [OFFSET_BITS-1:0]   l_st_i,
  input  logic [OFFSET_BITS-1:0]   l_dk_i,
  input  logic [OFFSET_BITS-1:0]   l_ln_i,
  input  logic                     l_tail_i,
  input  logic                     r_vld_i,
  input  logic [OFFSET_BITS-1:0]   r_st_i,
  input  logic [OFFSET_BITS-1:0]   r_dk_i,
  input  logic [OFFSET_BITS-1:0]   r_ln_i,
  input  logic                     r_tail_i,
  input  logic                     r_hole_i,
  input  logic                     r_cov_i,
  output sem_pkg::sem_flg_t        flg_o,
  output logic [OFFSET_BITS-1:0]   st_o,
  output logic [OFFSET_BITS-1:0]   dk_o,
  output logic [OFFSET_BITS-1:0]   ln_o,
  output logic [OFFSET_BITS-1:0]   c_dk_o,
  output logic [OFFSET_BITS-1:0]   c_ln_o,
  output logic [OFFSET_BITS-1:0]   c_st_o,
  output logic [OFFSET_BITS:0]     c_end_o
);
  import sem_pkg::*;

  localparam int W = OFFSET_BITS;

  logic vld_q, vld_d, hole_q, hole_d, tail_q, tail_d;
  logic lft_q, lft_d, rgt_q, rgt_d, cov_q, cov_d;
  logic mg_q, mg_d, rdv_q, rdv_d, nx_q, nx_d;
  logic [W-1:0] st_q, st_d, dk_q, dk_d, ln_q, ln_d;
  logic [W:0]   ce_q, ce_d;
  logic [W-1:0] trim_q, trim_d, eoff_q, eoff_d, rlen_q, rlen_d;
  logic [W-1:0] rdk_q, rdk_d, mlen_q, mlen_d;

  logic         lt_w, lt_r, prev, is_p, sp;
  logic [W:0]   key_x, st_x, psum, rl_x;
  logic [W-1:0] plen, pdk;

  assign key_x = {1'b0, key_i};
  assign st_x  = {1'b0, st_q};
  assign lt_w  = vld_q & (st_q < key_i);
  assign lt_r  = vld_q & (st_q <= key_i);
  assign prev  = !tail_q & r_tail_i;
  assign is_p  = tail_q & !l_tail_i;
  assign sp    = lft_q & rgt_q;
  assign plen  = lft_q ? trim_q : ln_q;
  assign psum  = {1'b0, plen} + {1'b0, len_i};
  assign pdk   = dk_q + plen;
  assign rl_x  = ce_q - end_i;

  always_comb begin
    vld_d  = vld_q;  hole_d = hole_q; tail_d = tail_q;
    lft_d  = lft_q;  rgt_d  = rgt_q;  cov_d  = cov_q;
    mg_d   = mg_q;   rdv_d  = rdv_q;  nx_d   = nx_q;
    st_d   = st_q;   dk_d   = dk_q;   ln_d   = ln_q;
    ce_d   = ce_q;   trim_d = trim_q; eoff_d = eoff_q;
    rlen_d = rlen_q; rdk_d  = rdk_q;  mlen_d = mlen_q;
    unique case (cmd_i.op)
      OP_PRE: begin
        ce_d = st_x + {1'b0, ln_q};
      end
      OP_CLS: begin
        mg_d   = 1'b0;
        rdv_d  = 1'b0;
        nx_d   = 1'b0;
        trim_d = key_i - st_q;
        eoff_d = end_i[W-1:0] - st_q;
        rlen_d = rl_x[W-1:0];
        if (cmd_i.wr) begin
          tail_d = !lt_w;
          lft_d  = lt_w & (ce_q > key_x);
          rgt_d  = vld_q & (st_x < end_i) & (ce_q > end_i);
          cov_d  = vld_q & !lt_w & (ce_q <= end_i);
        end else begin
          tail_d = !lt_r;
          lft_d  = 1'b0;
          rgt_d  = 1'b0;
          cov_d  = 1'b0;
        end
      end
      OP_EVL: begin
        rdk_d = dk_q + (cmd_i.wr ? eoff_q : trim_q);
        if (cmd_i.wr) begin
          // merge into the entry just below the new range
          mg_d   = prev & (lft_q | (ce_q == key_x)) & (pdk == dsk_i) & !psum[W];
          mlen_d = psum[W-1:0];
        end else begin
          rdv_d  = prev & (trim_q < ln_q);
          mlen_d = ln_q - trim_q;
          nx_d   = is_p & vld_q;
        end
      end
      OP_APL: begin
        if (cmd_i.wr && cmd_i.commit) begin
          priority if (cov_q) begin
            vld_d  = 1'b0;
            hole_d = 1'b1;
          end else if (mg_q) begin
            ln_d = mlen_q;
          end else if (lft_q) begin
            ln_d = trim_q;
          end else if (rgt_q) begin
            st_d = end_i[W-1:0];
            dk_d = rdk_q;
            ln_d = rlen_q;
          end
        end
      end
      OP_INS: begin
        if (is_p) begin
          vld_d  = 1'b1;
          hole_d = 1'b0;
          tail_d = 1'b0;
          st_d   = ins_st_i;
          dk_d   = ins_dk_i;
          ln_d   = ins_ln_i;
        end else if (tail_q && !cmd_i.any_hole) begin
          // open a slot: tail moves up by one
          vld_d  = l_vld_i;
          hole_d = 1'b0;
          st_d   = l_st_i;
          dk_d   = l_dk_i;
          ln_d   = l_ln_i;
        end
      end
      OP_SHL: begin
        if (tail_q) begin
          vld_d  = r_vld_i;
          hole_d = r_hole_i;
          st_d   = r_st_i;
          dk_d   = r_dk_i;
          ln_d   = r_ln_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      hole_q <= 1'b0;
      tail_q <= 1'b1;
      lft_q  <= 1'b0;
      rgt_q  <= 1'b0;
      cov_q  <= 1'b0;
      mg_q   <= 1'b0;
      rdv_q  <= 1'b0;
      nx_q   <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      hole_q <= hole_d;
      tail_q <= tail_d;
      lft_q  <= lft_d;
      rgt_q  <= rgt_d;
      cov_q  <= cov_d;
      mg_q   <= mg_d;
      rdv_q  <= rdv_d;
      nx_q   <= nx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    dk_q   <= dk_d;
    ln_q   <= ln_d;
    ce_q   <= ce_d;
    trim_q <= trim_d;
    eoff_q <= eoff_d;
    rlen_q <= rlen_d;
    rdk_q  <= rdk_d;
    mlen_q <= mlen_d;
  end

  assign flg_o.vld  = vld_q;
  assign flg_o.tail = tail_q;
  assign flg_o.hole = hole_q;
  assign flg_o.cov  = cov_q;
  assign flg_o.cov2 = cov_q & r_cov_i;
  assign flg_o.sp   = sp;
  assign flg_o.mg   = mg_q;
  assign flg_o.rdv  = rdv_q;
  assign flg_o.nx   = nx_q;

  assign st_o = st_q;
  assign dk_o = dk_q;
  assign ln_o = ln_q;

  assign c_dk_o  = (rdv_q | sp) ? rdk_q : '0;
  assign c_ln_o  = rdv_q ? mlen_q : (sp ? rlen_q : '0);
  assign c_st_o  = nx_q ? st_q : '0;
  assign c_end_o = rdv_q ? ce_q : '0;

endmodule
